// ===== design/atet_pkg.sv =====
// Shared types, codes and defaults of the aging tag exclusion table.
`default_nettype none

package atet_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int TAG_W    = 24;
  localparam int PORTAL_W = 16;
  localparam int COUNT_W  = 8;
  localparam int SLOT_W   = 6;
  localparam int EXPIRE_W = 7;
  localparam int CFG_W    = 8;
  localparam int INDEX_W  = 2;

  // input command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_ENTERED_TIMEOUT      = 2'd0;
  localparam logic [INDEX_W-1:0] REG_EXIT_TIMEOUT_NEW     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_EXIT_TIMEOUT_REFRESH = 2'd2;

  localparam logic [7:0]         PREFIX_A     = 8'h30;
  localparam logic [7:0]         PREFIX_B     = 8'h50;
  localparam logic [COUNT_W-1:0] EXPIRED_MARK = 8'hFF;

  typedef struct packed {
    logic [1:0]          command;
    logic [TAG_W-1:0]    tag_id;
    logic [PORTAL_W-1:0] portal_id;
    logic                direction;
  } item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot;
    logic [EXPIRE_W-1:0] expired_count;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_TICK   = 3'd3,
    OP_REFUSE = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [TAG_W-1:0]    tag;
    logic [PORTAL_W-1:0] portal;
    logic                direction;
  } op_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entered_timeout;
    logic [6:0]         exit_timeout_new;
    logic [6:0]         exit_timeout_refresh;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [PORTAL_W-1:0] portal;
    logic                direction;
    logic [COUNT_W-1:0]  countdown;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/atet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module atet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/atet_front.sv =====
// Front end: classify incoming words and hold them in a two-entry queue.
`default_nettype none

module atet_front
  import atet_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire item_t item,
  output logic       full,
  output logic       head_valid,
  output op_t        head,
  input  wire logic  take
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        classified;

  always_comb begin
    classified.tag       = item.tag_id;
    classified.portal    = item.portal_id;
    classified.direction = item.direction;
    unique case (item.command)
      CMD_ADD: begin
        if (item.tag_id[23:16] == PREFIX_A || item.tag_id[23:16] == PREFIX_B) begin
          classified.kind = OP_ADD;
        end else begin
          classified.kind = OP_REFUSE;
        end
      end
      CMD_REMOVE: classified.kind = OP_REMOVE;
      CMD_TICK:   classified.kind = OP_TICK;
      default:    classified.kind = OP_NONE;
    endcase
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/atet_back.sv =====
// Back end: clearing pass, table scans, entry updates and the result register.
`default_nettype none

module atet_back
  import atet_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire logic    head_valid,
  input  wire op_t     head,
  output logic         take,
  output logic         clearing,
  input  wire logic    pop,
  output logic         empty,
  output result_t      result
);

  localparam int IDXW = $clog2(TABLE_ENTRIES);
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_ENTRIES - 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t             state;
  op_t                op;
  logic [IDXW-1:0]    clr_idx;
  logic [IDXW-1:0]    rd_idx;
  logic               issuing;
  logic               chk_valid;
  logic [IDXW-1:0]    chk_idx;
  logic               found_tag;
  logic [IDXW-1:0]    tag_idx;
  logic               match_dir;
  logic [COUNT_W-1:0] match_cnt;
  logic               found_free;
  logic [IDXW-1:0]    free_idx;
  logic [CNTW-1:0]    exp_cnt;
  logic [CNTW-1:0]    exp_cnt_next;
  result_t            pend;
  result_t            pend_write;
  logic               res_valid;
  logic               load;

  logic               we;
  logic [IDXW-1:0]    waddr;
  entry_t             wdata;
  entry_t             rdata;

  logic [COUNT_W-1:0] aged_cnt;
  logic               tick_expire;
  entry_t             tick_entry;
  logic               tick_hit;
  logic [COUNT_W-1:0] add_cnt;

  atet_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  assign clearing = (state == S_CLEAR);
  assign take     = (state == S_IDLE) && head_valid;
  assign empty    = !res_valid;
  assign load     = (state == S_DONE) && (!res_valid || pop);

  // Tick aging of the entry returning from the RAM.
  always_comb begin
    if (!rdata.countdown[COUNT_W-1] && rdata.countdown != '0) begin
      aged_cnt = rdata.countdown - COUNT_W'(1);
    end else begin
      aged_cnt = rdata.countdown;
    end
    tick_hit    = chk_valid && (op.kind == OP_TICK) && rdata.direction;
    tick_expire = tick_hit && (aged_cnt == '0) && (rdata.tag[23:16] != 8'h00);
    if (tick_expire) begin
      tick_entry = '{tag: '0, portal: '0, direction: 1'b1, countdown: EXPIRED_MARK};
    end else begin
      tick_entry = '{tag: rdata.tag, portal: rdata.portal, direction: rdata.direction,
                     countdown: aged_cnt};
    end
    exp_cnt_next = exp_cnt + CNTW'(tick_expire);
  end

  // Write port and the result of an add or remove.
  always_comb begin
    we         = 1'b0;
    waddr      = chk_idx;
    wdata      = tick_entry;
    pend_write = '{status: ST_OK, slot: '0, expired_count: '0};
    if (op.direction) begin
      add_cnt = found_tag ? {1'b0, cfg.exit_timeout_refresh} : {1'b0, cfg.exit_timeout_new};
    end else begin
      add_cnt = cfg.entered_timeout;
    end
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_idx;
        wdata = '0;
      end
      S_SCAN: begin
        we = tick_hit;
      end
      S_WRITE: begin
        wdata = '{tag: op.tag, portal: op.portal, direction: op.direction, countdown: add_cnt};
        if (op.kind == OP_ADD) begin
          if (found_tag) begin
            we              = 1'b1;
            waddr           = tag_idx;
            pend_write.slot = SLOT_W'(tag_idx);
          end else if (found_free) begin
            we              = 1'b1;
            waddr           = free_idx;
            pend_write.slot = SLOT_W'(free_idx);
          end else begin
            pend_write.status = ST_FULL;
          end
        end else begin
          wdata = '{tag: '0, portal: '0, direction: match_dir, countdown: match_cnt};
          if (found_tag) begin
            we              = 1'b1;
            waddr           = tag_idx;
            pend_write.slot = SLOT_W'(tag_idx);
          end else begin
            pend_write.status = ST_NOT_FOUND;
          end
        end
      end
      S_IDLE, S_DONE: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Payload registers of the scan and the result register.
  always_ff @(posedge clk) begin
    if (take) begin
      op <= head;
    end
    chk_idx <= rd_idx;
    if (state == S_IDLE) begin
      exp_cnt <= '0;
    end else if (state == S_SCAN) begin
      exp_cnt <= exp_cnt_next;
    end
    if (state == S_SCAN && chk_valid && op.kind != OP_TICK) begin
      if (!found_tag && rdata.tag == op.tag) begin
        tag_idx   <= chk_idx;
        match_dir <= rdata.direction;
        match_cnt <= rdata.countdown;
      end
      if (!found_free && rdata.tag[23:16] == 8'h00) begin
        free_idx <= chk_idx;
      end
    end
    if (load) begin
      result <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      rd_idx     <= '0;
      issuing    <= 1'b0;
      chk_valid  <= 1'b0;
      found_tag  <= 1'b0;
      found_free <= 1'b0;
      res_valid  <= 1'b0;
      pend       <= '0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      chk_valid <= issuing;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDXW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            found_tag  <= 1'b0;
            found_free <= 1'b0;
            rd_idx     <= '0;
            unique case (head.kind) inside
              OP_ADD, OP_REMOVE, OP_TICK: begin
                issuing <= 1'b1;
                state   <= S_SCAN;
              end
              OP_REFUSE: begin
                pend  <= '{status: ST_REFUSED, slot: '0, expired_count: '0};
                state <= S_DONE;
              end
              default: begin
                pend  <= '{status: ST_OK, slot: '0, expired_count: '0};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            rd_idx <= rd_idx + IDXW'(1);
            if (rd_idx == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          if (chk_valid && op.kind != OP_TICK) begin
            if (rdata.tag == op.tag) begin
              found_tag <= 1'b1;
            end
            if (rdata.tag[23:16] == 8'h00) begin
              found_free <= 1'b1;
            end
          end
          if (chk_valid && chk_idx == LAST_IDX) begin
            if (op.kind == OP_TICK) begin
              pend  <= '{status: ST_OK, slot: '0, expired_count: EXPIRE_W'(exp_cnt_next)};
              state <= S_DONE;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          pend  <= pend_write;
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/aging_tag_exclusion_table.sv =====
// Top level of the aging tag exclusion table: ports, registers, front and back.
// Each add, remove or tick scans every entry through the one RAM read port; a refused
//   add or unused command skips the scan. The back end takes a new word only when idle
//   and its last result has been loaded into the result register; the front queue
//   holds up to two further words meanwhile.
// Reset: synchronous; the table is then cleared one entry a cycle with full high;
//   register writes are taken during that pass.
`default_nettype none

module aging_tag_exclusion_table
  import atet_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input words
  input  wire logic               push,
  output logic                    full,
  input  wire item_t              item,
  // result words
  output logic                    empty,
  input  wire logic               pop,
  output result_t                 result,
  // register writes
  input  wire logic               wr_en,
  input  wire logic [INDEX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]   wr_data
);

  cfg_t cfg;
  logic accept;
  logic queue_full;
  logic head_valid;
  op_t  head;
  logic take;
  logic clearing;

  // Hold off input while the queue is full or the table is being cleared.
  assign full   = queue_full || clearing;
  assign accept = push && !full;

  // Timeout registers; an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entered_timeout      <= 8'd127;
      cfg.exit_timeout_new     <= 7'd60;
      cfg.exit_timeout_refresh <= 7'd60;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ENTERED_TIMEOUT:      cfg.entered_timeout      <= wr_data;
        REG_EXIT_TIMEOUT_NEW:     cfg.exit_timeout_new     <= wr_data[6:0];
        REG_EXIT_TIMEOUT_REFRESH: cfg.exit_timeout_refresh <= wr_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Front: classify each word (prefix check included) and queue it.
  atet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  // Back: scan the table, apply the update and hold the result word.
  atet_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .clearing   (clearing),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== verif/aging_tag_exclusion_table_tb.sv =====
// Self-checking testbench for the aging tag exclusion table: predicted results, random traffic.
`timescale 1ns / 100ps

module aging_tag_exclusion_table_tb;
  import atet_pkg::*;

  localparam int          ENTRIES        = TABLE_ENTRIES_DEF;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int          POOL_SIZE      = 96;
  localparam int          HOLD_CYCLES    = 3000;
  localparam int          WATCHDOG_LIMIT = 12000;
  localparam int          IDLE_PCT       = 26;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  item_t               item;
  logic                empty;
  logic                pop;
  result_t             result;
  logic                wr_en;
  logic [INDEX_W-1:0]  wr_index;
  logic [CFG_W-1:0]    wr_data;

  // Shared control between the stimulus and the pop driver.
  logic calm = 1'b0;     // no idling on either side while set
  int   hold_seq = 0;    // bump to make the receiver start a counted hold-off
  int   fail_count = 0;

  // Predicted copy of the table and of the timeout registers.
  logic [TAG_W-1:0]    tbl_tag    [ENTRIES];
  logic [PORTAL_W-1:0] tbl_portal [ENTRIES];
  logic                tbl_dir    [ENTRIES];
  logic [COUNT_W-1:0]  tbl_count  [ENTRIES];
  logic [COUNT_W-1:0]  entered_to;
  logic [6:0]          exit_new_to;
  logic [6:0]          exit_refresh_to;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  // Tags that random traffic draws from, so that adds and removes hit each other.
  logic [TAG_W-1:0] tag_pool [POOL_SIZE];

  aging_tag_exclusion_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  // First entry holding exactly this tag, or -1.
  function automatic int match_entry(logic [TAG_W-1:0] tag);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_tag[i] == tag) return i;
    return -1;
  endfunction

  // Apply one word to the predicted table and return the result it must give.
  function automatic result_t table_step(item_t w);
    result_t r;
    int      pos;
    int      freed;
    logic [7:0] first_byte;
    r          = '0;
    freed      = 0;
    first_byte = w.tag_id[23:16];
    case (w.command)
      CMD_ADD: begin
        if (first_byte != PREFIX_A && first_byte != PREFIX_B) begin
          r.status = ST_REFUSED;
        end else begin
          pos = match_entry(w.tag_id);
          if (pos < 0) begin
            // take the first slot whose tag has a zero first byte
            for (int i = 0; i < ENTRIES; i++) begin
              if (pos < 0 && tbl_tag[i][23:16] == 8'h00) pos = i;
            end
            if (pos < 0) begin
              r.status = ST_FULL;
            end else begin
              tbl_tag[pos]   = w.tag_id;
              tbl_count[pos] = w.direction ? {1'b0, exit_new_to} : entered_to;
            end
          end else begin
            tbl_count[pos] = w.direction ? {1'b0, exit_refresh_to} : entered_to;
          end
          if (pos >= 0) begin
            tbl_portal[pos] = w.portal_id;
            tbl_dir[pos]    = w.direction;
            r.slot          = pos[SLOT_W-1:0];
          end
        end
      end
      CMD_REMOVE: begin
        // direction and count stay behind in the freed slot
        pos = match_entry(w.tag_id);
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          tbl_tag[pos]    = '0;
          tbl_portal[pos] = '0;
          r.slot          = pos[SLOT_W-1:0];
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_dir[i]) begin
            // count down positive counts only; negative ones hold
            if (tbl_count[i] != 8'd0 && !tbl_count[i][7]) tbl_count[i] = tbl_count[i] - 8'd1;
            if (tbl_count[i] == 8'd0 && tbl_tag[i][23:16] != 8'h00) begin
              tbl_tag[i]    = '0;
              tbl_portal[i] = '0;
              tbl_count[i]  = EXPIRED_MARK;
              freed++;
            end
          end
        end
        r.expired_count = freed[EXPIRE_W-1:0];
      end
      default: ;  // unused command: no effect, all-zero result
    endcase
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Monitor and checker: sample both handshakes and register writes at
  // the edge, compare results before adding the prediction for the word
  // accepted at the same edge.
  // ------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_tag[i]    = '0;
        tbl_portal[i] = '0;
        tbl_dir[i]    = 1'b0;
        tbl_count[i]  = '0;
      end
      entered_to      = 8'd127;
      exit_new_to     = 7'd60;
      exit_refresh_to = 7'd60;
      pending_results.delete();
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing expected: status %0d slot %0d expired %0d",
                 result.status, result.slot, result.expired_count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, result.status);
            fail_count++;
          end
          if (result.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, result.slot);
            fail_count++;
          end
          if (result.expired_count !== want.expired_count) begin
            $error("expired_count: expected %0d, actual %0d",
                   want.expired_count, result.expired_count);
            fail_count++;
          end
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_ENTERED_TIMEOUT:      entered_to      = wr_data;
          REG_EXIT_TIMEOUT_NEW:     exit_new_to     = wr_data[6:0];
          REG_EXIT_TIMEOUT_REFRESH: exit_refresh_to = wr_data[6:0];
          default: ;
        endcase
      end
      if (push && !full) pending_results.push_back(table_step(item));
    end
  end

  // Watchdog: count cycles in which neither side moves a word.
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Pop driver: random stalls, none while calm, and a long counted hold-off
  // whenever hold_seq moves.
  initial begin : drive_pop
    int hold_seen;
    hold_seen = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic item_t make_word(logic [1:0] cmd, logic [TAG_W-1:0] tag,
                                      logic [PORTAL_W-1:0] portal, logic dir);
    item_t w;
    w.command   = cmd;
    w.tag_id    = tag;
    w.portal_id = portal;
    w.direction = dir;
    return w;
  endfunction

  // Offer one word and return at the edge that accepts it. Push stays high
  // so that back-to-back words need no second assignment in one step.
  task automatic send_word(input item_t w);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
  endtask

  // Drop push and hold until every predicted result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
  endtask

  // Reprogram all three timeouts with the block idle.
  task automatic set_timeouts(input int entered, input int exit_new, input int exit_refresh);
    drain_results();
    write_reg(REG_ENTERED_TIMEOUT, 8'(entered));
    write_reg(REG_EXIT_TIMEOUT_NEW, 8'(exit_new));
    write_reg(REG_EXIT_TIMEOUT_REFRESH, 8'(exit_refresh));
    wr_en <= 1'b0;
  endtask

  // Mostly well-formed traffic over the tag pool, some noise on top.
  function automatic item_t random_word();
    int unsigned pick;
    item_t       w;
    pick        = $urandom_range(99);
    w.portal_id = 16'($urandom);
    w.direction = 1'($urandom);
    w.tag_id    = tag_pool[$urandom_range(POOL_SIZE - 1)];
    if (pick < 42) begin
      w.command = CMD_ADD;
    end else if (pick < 62) begin
      w.command = CMD_REMOVE;
    end else if (pick < 84) begin
      w.command = CMD_TICK;
    end else if (pick < 88) begin
      w.command = CMD_UNUSED;
      w.tag_id  = 24'($urandom);
    end else if (pick < 95) begin
      // arbitrary tag: mostly refused by prefix
      w.command = CMD_ADD;
      w.tag_id  = 24'($urandom);
    end else begin
      w.command = CMD_REMOVE;
      w.tag_id  = $urandom_range(1) ? 24'h000000 : 24'($urandom);
    end
    return w;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_word(random_word());
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Short exit timeouts so that aging shows within a few ticks.
  task automatic test_directed();
    set_timeouts(127, 1, 2);
    send_word(make_word(CMD_ADD, 24'h300000, 16'h0000, 1'b0));     // new entered, slot 0
    send_word(make_word(CMD_ADD, 24'h50FFFF, 16'hFFFF, 1'b1));     // new exited, slot 1
    send_word(make_word(CMD_ADD, 24'h000000, 16'h1111, 1'b0));     // refused: zero prefix
    send_word(make_word(CMD_ADD, 24'hFFFFFF, 16'hFFFF, 1'b1));     // refused: all ones
    send_word(make_word(CMD_ADD, 24'h312345, 16'h2222, 1'b0));     // refused: near prefix
    send_word(make_word(CMD_ADD, 24'h4FFFFF, 16'h3333, 1'b1));     // refused: near prefix
    send_word(make_word(CMD_ADD, 24'h50FFFF, 16'h1234, 1'b1));     // refresh exited
    send_word(make_word(CMD_TICK, 24'h000000, 16'h0000, 1'b0));    // count down, none free
    send_word(make_word(CMD_TICK, 24'hFFFFFF, 16'hFFFF, 1'b1));    // slot 1 expires
    send_word(make_word(CMD_REMOVE, 24'h50FFFF, 16'h0000, 1'b0));  // gone: not found
    send_word(make_word(CMD_REMOVE, 24'h000000, 16'h0000, 1'b0));  // tag zero hits a free slot
    send_word(make_word(CMD_REMOVE, 24'h300000, 16'h0000, 1'b0));  // remove slot 0
    send_word(make_word(CMD_ADD, 24'h305A5A, 16'h5A5A, 1'b1));     // reuse slot 0, exited
    send_word(make_word(CMD_ADD, 24'h500001, 16'hA5A5, 1'b0));     // reuse slot 1, entered
    send_word(make_word(CMD_ADD, 24'h300000, 16'h8000, 1'b0));     // slot 2
    send_word(make_word(CMD_TICK, 24'h000000, 16'h0000, 1'b0));    // slot 0 expires
    send_word(make_word(CMD_TICK, 24'h000000, 16'h0000, 1'b0));    // expired mark holds
    send_word(make_word(CMD_ADD, 24'h300000, 16'h0001, 1'b1));     // entered to exited
    send_word(make_word(CMD_REMOVE, 24'h123456, 16'h0000, 1'b1));  // never added
    send_word(make_word(CMD_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b1));  // unused command
    send_word(make_word(CMD_UNUSED, 24'h000000, 16'h0000, 1'b0));
    send_word(make_word(CMD_REMOVE, 24'h000000, 16'h0000, 1'b0));  // tag zero, free slot 0
    send_word(make_word(CMD_TICK, 24'h000000, 16'h0000, 1'b1));
    send_word(make_word(CMD_TICK, 24'h000000, 16'h0000, 1'b0));    // slot 2 expires
  endtask

  // Overfill the table, poke it while full, then remove the tags of the fill again.
  task automatic test_table_full();
    set_timeouts(-128, 127, 127);
    for (int i = 0; i < ENTRIES + 6; i++)
      send_word(make_word(CMD_ADD, {8'h30, 16'hA000 + 16'(i)}, 16'($urandom), i[0]));
    send_word(make_word(CMD_ADD, 24'h30A003, 16'hBEEF, 1'b1));     // update while full
    send_word(make_word(CMD_REMOVE, 24'h000000, 16'h0000, 1'b0));  // no free slot to match
    send_word(make_word(CMD_TICK, 24'h000000, 16'h0000, 1'b0));
    send_word(make_word(CMD_REMOVE, 24'h30A00A, 16'h0000, 1'b0));
    send_word(make_word(CMD_ADD, 24'h50C0DE, 16'h0F0F, 1'b0));     // takes the hole
    for (int i = 0; i < ENTRIES + 6; i++)
      send_word(make_word(CMD_REMOVE, {8'h30, 16'hA000 + 16'(i)}, 16'h0000, 1'b0));
  endtask

  // Random traffic under extreme and random timeout settings.
  task automatic test_random_settings();
    set_timeouts(0, 3, 5);
    run_random(350);
    set_timeouts(-128, 1, 1);
    run_random(350);
    set_timeouts(127, 127, 127);
    run_random(350);
    set_timeouts(int'($urandom_range(255)) - 128, $urandom_range(1, 127),
                 $urandom_range(1, 127));
    run_random(350);
  endtask

  // No idling on either side for a long stretch.
  task automatic test_calm_stretch();
    set_timeouts(int'($urandom_range(255)) - 128, $urandom_range(1, 8), $urandom_range(1, 8));
    calm <= 1'b1;
    run_random(300);
    calm <= 1'b0;
  endtask

  // Receiver stops popping while the sender keeps going, so the block backs up.
  task automatic test_receiver_holdoff();
    drain_results();
    hold_seq <= hold_seq + 1;
    calm     <= 1'b1;
    run_random(60);
    calm     <= 1'b0;
  endtask

  // Sender pauses mid-stream until everything has come back.
  task automatic test_drain_pause();
    run_random(100);
    drain_results();
    run_random(100);
  endtask

  initial begin : run_tests
    for (int i = 0; i < POOL_SIZE; i++)
      tag_pool[i] = {($urandom_range(1) ? PREFIX_A : PREFIX_B), 16'($urandom)};
    tag_pool[0] = {PREFIX_A, 16'h0000};
    tag_pool[1] = {PREFIX_B, 16'hFFFF};

    rst      <= 1'b1;
    push     <= 1'b0;
    item     <= '0;
    wr_en    <= 1'b0;
    wr_index <= '0;
    wr_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_table_full();
    test_random_settings();
    test_calm_stretch();
    test_receiver_holdoff();
    test_drain_pause();

    // Everything owed has come; give stray words a chance to show.
    drain_results();
    repeat (ENTRIES + 16) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== aging_tag_exclusion_table.f =====
design/atet_pkg.sv
design/atet_ram.sv
design/atet_front.sv
design/atet_back.sv
design/aging_tag_exclusion_table.sv
verif/aging_tag_exclusion_table_tb.sv
